// File: sv/positional_insert_remove_list_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the positional insert/remove list
// Wraps concurrent property checks; the bodies are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_REMOVE_LIST_ASSERT_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define PIRL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PIRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PIRL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define PIRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/pirl_pkg.sv
// ----------------------------------------------------------------------------
// Positional insert/remove list package
// Sizes, opcodes and status codes shared by the list block.
// ----------------------------------------------------------------------------
package pirl_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 11;
    localparam int ST_W     = 2;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_DATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: sv/positional_insert_remove_list.sv
// ----------------------------------------------------------------------------
// Positional insert/remove list
// Ordered store of signed 32-bit entries held in one synchronous memory.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream: tuser carries the opcode (read,
// insert, remove), tdata carries position and value. Each request gives
// one word on the master stream: tdata carries the read value and the
// length after the request, tuser the status (ok, out of range, full).
// Only one request is in work at a time; a new one is taken once the
// previous one has left the memory sequencer, even while its result still
// waits in the output register.
// A read passes through a memory read state on its way to the output register;
// a rejected request goes there directly. An insert or remove moves its later
// entries one memory read and one write per cycle, as the block has a single
// memory port pair.
// Reset clears the length and the control state at once; the memory is not
// cleared, entries are only read after they were written.
// When the receiver stalls, the result holds in the output register and the
// block finishes at most one more request, which then waits for the output.
// ----------------------------------------------------------------------------
module positional_insert_remove_list (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [9:0] position, [41:10] value, [47:42] zero
    input  logic [pirl_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // [1:0] opcode
    input  logic [pirl_pkg::OP_W-1:0]             i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [31:0] read_value, [42:32] length, [47:43] zero
    output logic [pirl_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // [1:0] status
    output logic [pirl_pkg::ST_W-1:0]             o_m_axis_tuser
);

`include "positional_insert_remove_list_assert.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    localparam int ADDR_W = pirl_pkg::ADDR_W;
    localparam int CNT_W  = pirl_pkg::CNT_W;
    localparam int CMP_W  = pirl_pkg::CMP_W;
    localparam int VAL_W  = pirl_pkg::VAL_W;

    logic [VAL_W-1:0]          r_mem [pirl_pkg::CAPACITY];
    logic [VAL_W-1:0]          r_rdata;

    logic [1:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_left,  n_left;
    logic [ADDR_W-1:0]         r_idx,   n_idx;
    logic [ADDR_W-1:0]         r_waddr, n_waddr;
    logic                      r_pend,  n_pend;
    logic                      r_ins,   n_ins;
    logic [ADDR_W-1:0]         r_pos,   n_pos;
    logic [VAL_W-1:0]          r_val,   n_val;
    logic [VAL_W-1:0]          r_rdval, n_rdval;
    logic [pirl_pkg::ST_W-1:0] r_st,    n_st;

    logic                                r_ovalid, n_ovalid;
    logic [pirl_pkg::OUT_DATA_W-1:0]     r_odata,  n_odata;
    logic [pirl_pkg::ST_W-1:0]           r_ouser,  n_ouser;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [VAL_W-1:0]          wr_data;

    logic                      in_acc;
    logic                      out_load;
    logic [pirl_pkg::OP_W-1:0] in_op;
    logic [pirl_pkg::POS_W-1:0] in_pos;
    logic [VAL_W-1:0]          in_val;
    logic [CMP_W-1:0]          pos_c;
    logic [CMP_W-1:0]          cnt_c;

    assign in_op  = i_s_axis_tuser;
    assign in_pos = i_s_axis_tdata[pirl_pkg::POS_W-1:0];
    assign in_val = i_s_axis_tdata[pirl_pkg::POS_W +: VAL_W];
    assign pos_c  = CMP_W'(in_pos);
    assign cnt_c  = CMP_W'(r_count);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_PUT) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        n_idx   = r_idx;
        n_waddr = r_waddr;
        n_pend  = r_pend;
        n_ins   = r_ins;
        n_pos   = r_pos;
        n_val   = r_val;
        n_rdval = r_rdval;
        n_st    = r_st;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(in_pos);
        wr_en   = 1'b0;
        wr_addr = r_waddr;
        wr_data = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rdval = '0;
                    n_st    = pirl_pkg::ST_OK;
                    n_pend  = 1'b0;
                    n_ins   = (in_op == pirl_pkg::OP_INSERT);
                    n_pos   = ADDR_W'(in_pos);
                    n_val   = in_val;
                    n_state = S_PUT;
                    unique case (in_op)
                        pirl_pkg::OP_READ: begin
                            if (pos_c < cnt_c) begin
                                rd_en   = 1'b1;
                                n_state = S_READ;
                            end else begin
                                n_st = pirl_pkg::ST_RANGE;
                            end
                        end
                        pirl_pkg::OP_INSERT: begin
                            if (pos_c > cnt_c) begin
                                n_st = pirl_pkg::ST_RANGE;
                            end else if (r_count >= CNT_W'(pirl_pkg::CAPACITY)) begin
                                n_st = pirl_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                                n_left  = r_count - CNT_W'(in_pos);
                                n_idx   = ADDR_W'(r_count - 1'b1);
                                n_state = S_SHIFT;
                            end
                        end
                        pirl_pkg::OP_REMOVE: begin
                            if (pos_c >= cnt_c) begin
                                n_st = pirl_pkg::ST_RANGE;
                            end else begin
                                n_count = r_count - 1'b1;
                                n_left  = r_count - CNT_W'(in_pos) - 1'b1;
                                n_idx   = ADDR_W'(in_pos) + 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_st = pirl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rdval = r_rdata;
                n_state = S_PUT;
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_waddr;
                    wr_data = r_rdata;
                end
                if (r_left != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx;
                    n_pend  = 1'b1;
                    n_left  = r_left - 1'b1;
                    n_waddr = r_ins ? (r_idx + 1'b1) : (r_idx - 1'b1);
                    n_idx   = r_ins ? (r_idx - 1'b1) : (r_idx + 1'b1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_ins) begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos;
                            wr_data = r_val;
                        end
                        n_state = S_PUT;
                    end
                end
            end
            S_PUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        if (out_load) begin
            n_ovalid = 1'b1;
            n_odata  = {(pirl_pkg::OUT_DATA_W - VAL_W - pirl_pkg::LEN_W)'(0),
                        pirl_pkg::LEN_W'(r_count), r_rdval};
            n_ouser  = r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_idx   <= n_idx;
        r_waddr <= n_waddr;
        r_ins   <= n_ins;
        r_pos   <= n_pos;
        r_val   <= n_val;
        r_rdval <= n_rdval;
        r_st    <= n_st;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `PIRL_ASSERT_IMPL(a_no_same_entry, i_clk, i_rst_n, rd_en && wr_en, rd_addr != wr_addr,
        "read and write hit the same entry")
    `PIRL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE,
        "accepted word did not start work")
    `PIRL_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_IDLE, $stable(r_count),
        "length changed while a request is in work")
    `PIRL_ASSERT_NEXT(a_put_loads, i_clk, i_rst_n, out_load, r_ovalid && r_state == S_IDLE,
        "result not loaded into output register")
    `PIRL_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(pirl_pkg::CAPACITY), "length beyond capacity")

endmodule

// File: tb/tb_positional_insert_remove_list.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the positional insert/remove list
// Drives read, insert, remove and unused-opcode requests over the slave stream.
// A software copy of the list predicts each reply, and replies taken from the
// master stream are checked field by field and in order. Both sides idle at random.
// The run covers empty and partly filled lists.
// ----------------------------------------------------------------------------
module tb_positional_insert_remove_list;

    localparam int CAPACITY   = pirl_pkg::CAPACITY;
    localparam int OP_W       = pirl_pkg::OP_W;
    localparam int POS_W      = pirl_pkg::POS_W;
    localparam int VAL_W      = pirl_pkg::VAL_W;
    localparam int LEN_W      = pirl_pkg::LEN_W;
    localparam int ST_W       = pirl_pkg::ST_W;
    localparam int IN_DATA_W  = pirl_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = pirl_pkg::OUT_DATA_W;

    localparam logic [OP_W-1:0] OP_READ   = pirl_pkg::OP_READ;
    localparam logic [OP_W-1:0] OP_INSERT = pirl_pkg::OP_INSERT;
    localparam logic [OP_W-1:0] OP_REMOVE = pirl_pkg::OP_REMOVE;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = pirl_pkg::ST_OK;
    localparam logic [ST_W-1:0] ST_RANGE = pirl_pkg::ST_RANGE;
    localparam logic [ST_W-1:0] ST_FULL  = pirl_pkg::ST_FULL;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        int               gap;
        bit               drain;
    } t_list_request;

    typedef struct {
        logic [VAL_W-1:0] rd;
        logic [LEN_W-1:0] len;
        logic [ST_W-1:0]  st;
    } t_list_reply;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic [OP_W-1:0]       s_user  = '0;
    logic                  m_ready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [ST_W-1:0]       o_m_axis_tuser;

    t_list_request pending_requests[$];
    t_list_reply   expected_replies[$];
    t_list_request cur_req;

    logic [VAL_W-1:0] list_entries [CAPACITY];
    int unsigned      list_len  = 0;
    int unsigned      peak_len  = 0;
    int unsigned      gen_len   = 0;
    int               gap_run   = 0;
    bit               gap_free  = 1'b0;
    int               idle_left = 0;
    int               stall_left = 0;
    int               stall_run = 0;
    bit               stall_free = 1'b0;
    int               errors    = 0;
    int               op_seen [4];
    int               st_seen [4];

    positional_insert_remove_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #120_000_000;
        $display("positional_insert_remove_list verification failed");
        $finish;
    end

    function automatic t_list_reply apply_request(t_list_request req);
        t_list_reply rep;
        int unsigned p;
        p      = 32'(req.pos);
        rep.rd = '0;
        rep.st = ST_OK;
        unique case (req.op)
            OP_READ: begin
                if (p < list_len) rep.rd = list_entries[p];
                else rep.st = ST_RANGE;
            end
            OP_INSERT: begin
                if (p > list_len) begin
                    rep.st = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    rep.st = ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) list_entries[i] = list_entries[i-1];
                    list_entries[p] = req.val;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (p >= list_len) begin
                    rep.st = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        rep.len = list_len[LEN_W-1:0];
        if (list_len > peak_len) peak_len = list_len;
        return rep;
    endfunction

    task automatic queue_request(input logic [OP_W-1:0] op, input int unsigned pos,
                                 input logic [VAL_W-1:0] val, input bit drain);
        t_list_request req;
        if (gap_run == 0) begin
            gap_free = ($urandom_range(0, 3) == 0);
            gap_run  = $urandom_range(10, 60);
        end
        gap_run--;
        if (pos > 1023) pos = 1023;
        req.op    = op;
        req.pos   = pos[POS_W-1:0];
        req.val   = val;
        req.gap   = gap_free ? 0 : $urandom_range(0, 15);
        req.drain = drain;
        unique case (op)
            OP_INSERT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
            OP_REMOVE: if (pos < gen_len) gen_len--;
            default: ;
        endcase
        pending_requests.push_back(req);
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_list_reply rep;
        bit          busy;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            s_data    <= '0;
            s_user    <= '0;
            idle_left = 0;
        end else begin
            busy = s_valid;
            if (s_valid && o_s_axis_tready) begin
                rep = apply_request(cur_req);
                expected_replies.push_back(rep);
                op_seen[cur_req.op]++;
                st_seen[rep.st]++;
                busy = 1'b0;
                idle_left = (pending_requests.size() > 0) ? pending_requests[0].gap : 0;
            end
            if (!busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain && expected_replies.size() != 0)) begin
                    cur_req = pending_requests.pop_front();
                    busy    = 1'b1;
                    s_data  <= {{(IN_DATA_W - POS_W - VAL_W){1'b0}}, cur_req.val, cur_req.pos};
                    s_user  <= cur_req.op;
                end
            end
            s_valid <= busy;
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_list_reply      want;
        logic [VAL_W-1:0] got_rd;
        logic [LEN_W-1:0] got_len;
        logic [ST_W-1:0]  got_st;
        if (!i_rst_n) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got_rd  = o_m_axis_tdata[VAL_W-1:0];
                got_len = o_m_axis_tdata[VAL_W+LEN_W-1:VAL_W];
                got_st  = o_m_axis_tuser;
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual rd=%h len=%0d st=%0d",
                             $time, got_rd, got_len, got_st);
                end else begin
                    want = expected_replies.pop_front();
                    if (got_rd !== want.rd) begin
                        errors++;
                        $display("%0t: read_value expected %h actual %h", $time, want.rd, got_rd);
                    end
                    if (got_len !== want.len) begin
                        errors++;
                        $display("%0t: length expected %0d actual %0d", $time, want.len, got_len);
                    end
                    if (got_st !== want.st) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, want.st, got_st);
                    end
                end
                if (stall_run == 0) begin
                    stall_free = ($urandom_range(0, 3) == 0);
                    stall_run  = $urandom_range(10, 60);
                end
                stall_run--;
                stall_left = stall_free ? 0 : $urandom_range(0, 15);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned ins_lim;

        queue_request(OP_READ,   0,    32'h1234_5678, 1'b0);
        queue_request(OP_REMOVE, 0,    32'h0,         1'b0);
        queue_request(OP_INSERT, 1,    32'h5555_5555, 1'b0);
        queue_request(OP_UNUSED, 0,    32'h0,         1'b0);
        queue_request(OP_INSERT, 0,    32'h8000_0000, 1'b0);
        queue_request(OP_INSERT, 1,    32'h7FFF_FFFF, 1'b0);
        queue_request(OP_INSERT, 0,    32'hFFFF_FFFF, 1'b0);
        queue_request(OP_INSERT, 1,    32'h0000_0000, 1'b0);
        queue_request(OP_INSERT, 4,    32'hA5A5_5A5A, 1'b0);
        queue_request(OP_READ,   0,    32'h0,         1'b0);
        queue_request(OP_READ,   1,    32'h0,         1'b0);
        queue_request(OP_READ,   2,    32'h0,         1'b0);
        queue_request(OP_READ,   4,    32'h0,         1'b0);
        queue_request(OP_READ,   5,    32'h0,         1'b0);
        queue_request(OP_READ,   1023, 32'h0,         1'b0);
        queue_request(OP_INSERT, 1023, 32'h1111_1111, 1'b0);
        queue_request(OP_INSERT, 6,    32'h2222_2222, 1'b0);
        queue_request(OP_REMOVE, 4,    32'h0,         1'b0);
        queue_request(OP_REMOVE, 0,    32'h0,         1'b0);
        queue_request(OP_REMOVE, 5,    32'h0,         1'b0);
        queue_request(OP_REMOVE, 1023, 32'h0,         1'b0);
        queue_request(OP_UNUSED, 1023, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_READ,   2,    32'h0,         1'b0);

        repeat (545) begin
            r       = $urandom_range(0, 99);
            ins_lim = (gen_len < 150) ? 60 : 40;
            if (r < 8)
                queue_request(OP_W'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom,
                              r == 0);
            else if (gen_len == 0 || r < ins_lim)
                queue_request(OP_INSERT, $urandom_range(0, gen_len), $urandom,
                              $urandom_range(0, 99) < 3);
            else if (r < 80)
                queue_request(OP_REMOVE, $urandom_range(0, gen_len - 1), 32'h0,
                              $urandom_range(0, 99) < 3);
            else
                queue_request(OP_READ, $urandom_range(0, gen_len - 1), $urandom,
                              $urandom_range(0, 99) < 3);
        end

        // hold until every reply is back, then probe the ends of the list
        queue_request(OP_READ,   gen_len,     32'h0,   1'b1);
        queue_request(OP_INSERT, gen_len + 1, $urandom, 1'b0);
        queue_request(OP_REMOVE, gen_len,     32'h0,   1'b0);
        queue_request(OP_READ,   0,           32'h0,   1'b0);

        wait (i_rst_n);
        while (pending_requests.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Covered %0d reads, %0d inserts, %0d removes, %0d unused opcodes; peak length %0d.",
                 op_seen[OP_READ], op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_UNUSED],
                 peak_len);
        $display("Replies: %0d ok, %0d out of range, %0d full; %0d mismatches.",
                 st_seen[ST_OK], st_seen[ST_RANGE], st_seen[ST_FULL], errors);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("positional_insert_remove_list verification clean");
        end else begin
            $display("positional_insert_remove_list verification failed");
        end
        $finish;
    end

endmodule
